// ===== rtl/msdp_pkg.sv =====
// ----------------------------------------------------------------------------
// msdp_pkg
// Shared types and constants of the media status datagram parser.
// ----------------------------------------------------------------------------
package msdp_pkg;

   localparam int NAME_UNITS_DEFAULT = 32;
   localparam int NAME_ADDR_W        = 5;
   localparam int JOB_DEPTH          = 2;
   localparam int RES_DEPTH          = 2;

   localparam logic [15:0] BYTE_COUNT_MAX = 16'hFFFF;
   localparam logic [15:0] OFF_MAGIC_LAST = 16'h000A;
   localparam logic [15:0] OFF_TYPE       = 16'h000A;
   localparam logic [15:0] OFF_SENDER     = 16'h0021;
   localparam logic [15:0] OFF_DEVICE     = 16'h0024;
   localparam logic [15:0] OFF_SLOT_LOW   = 16'h002B;
   localparam logic [15:0] OFF_NAME       = 16'h002C;
   localparam logic [15:0] NAME_BYTES     = 16'h0040;
   localparam logic [15:0] OFF_MASTER     = 16'h009E;
   localparam logic [15:0] OFF_TRACKS     = 16'h00A4;
   localparam logic [15:0] OFF_PLAYLISTS  = 16'h00AC;
   localparam logic [15:0] STATUS_MIN_LEN = 16'h009F;
   localparam logic [15:0] RESP_MIN_LEN   = 16'h00B0;
   localparam logic [7:0]  TYPE_STATUS    = 8'h0A;
   localparam logic [7:0]  TYPE_RESPONSE  = 8'h06;

   localparam logic [7:0] CSR_MAGIC_FIRST_EIGHT = 8'd0;
   localparam logic [7:0] CSR_MAGIC_LAST_TWO    = 8'd1;

   typedef enum logic [1:0] {
      REC_NAME    = 2'd0,
      REC_SUMMARY = 2'd1,
      REC_MASTER  = 2'd2
   } record_kind_type;

   typedef enum logic {
      JOB_MASTER = 1'b0,
      JOB_MEDIA  = 1'b1
   } job_kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MASTER,
      BK_READ,
      BK_UNIT,
      BK_SUMMARY
   } back_state_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   master;
      logic [31:0]  device;
      logic [7:0]   slot;
      logic [31:0]  tracks;
      logic [31:0]  playlists;
   } job_type;

   typedef struct packed {
      logic                   en;
      logic [NAME_ADDR_W-1:0] addr;
      logic [15:0]            data;
   } name_write_type;

   typedef struct packed {
      record_kind_type kind;
      logic [15:0]     name_unit;
      logic [31:0]     device;
      logic [7:0]      slot;
      logic [31:0]     tracks;
      logic [31:0]     playlists;
      logic [7:0]      master;
      logic            last;
   } result_type;

endpackage

// ===== rtl/msdp_queue.sv =====
// ----------------------------------------------------------------------------
// msdp_queue
// Small register queue with push and pop, used for jobs and for results.
// ----------------------------------------------------------------------------
module msdp_queue
   import msdp_pkg::*;
#(
   parameter type ITEM_TYPE = job_type,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  ITEM_TYPE push_data,
   output logic     full,
   input  logic     pop,
   output ITEM_TYPE head,
   output logic     empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ITEM_TYPE        entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/msdp_front.sv =====
// ----------------------------------------------------------------------------
// msdp_front
// Byte intake: header check, field capture, name writes, datagram sorting.
// ----------------------------------------------------------------------------
module msdp_front
   import msdp_pkg::*;
#(
   parameter int NAME_UNITS = NAME_UNITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   output logic           req_full,
   input  logic [7:0]     req_data_byte,
   input  logic           req_last_byte,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [7:0]     csr_index,
   input  logic [63:0]    csr_data,
   output logic           job_push,
   output job_type        job_data,
   input  logic           job_full,
   input  logic           media_done,
   output name_write_type name_write,
   output logic           locked
);

   logic [63:0] magic_first_ff;
   logic [15:0] magic_last_ff;
   logic [15:0] byte_count_ff, byte_count_in;
   logic        magic_match_ff, magic_match_in;
   logic [7:0]  type_code_ff, type_code_in;
   logic [7:0]  sender_ff, sender_in;
   logic        claimed_ff, claimed_in;
   logic [31:0] device_ff, device_in;
   logic [7:0]  slot_ff, slot_in;
   logic [31:0] tracks_ff, tracks_in;
   logic [31:0] playlists_ff, playlists_in;
   logic [7:0]  master_ff, master_in;
   logic [7:0]  name_hi_ff, name_hi_in;
   logic        lock_ff, lock_in;

   logic        accept;
   logic [15:0] off;
   logic [15:0] rel;
   logic [2:0]  magic_sel;
   logic [7:0]  expect_byte;
   logic        frame_ok;

   assign csr_ready = 1'b1;
   assign req_full  = lock_ff || job_full;
   assign accept    = req_push && !req_full;
   assign off       = byte_count_ff;
   assign rel       = off - OFF_NAME;
   assign magic_sel = 3'd7 - off[2:0];
   assign locked    = lock_ff;

   always_comb begin
      if (off < 16'd8) begin
         expect_byte = magic_first_ff[{magic_sel, 3'b000} +: 8];
      end else begin
         expect_byte = magic_last_ff[{~off[0], 3'b000} +: 8];
      end
   end

   always_comb begin
      byte_count_in  = byte_count_ff;
      magic_match_in = magic_match_ff;
      type_code_in   = type_code_ff;
      sender_in      = sender_ff;
      claimed_in     = claimed_ff;
      device_in      = device_ff;
      slot_in        = slot_ff;
      tracks_in      = tracks_ff;
      playlists_in   = playlists_ff;
      master_in      = master_ff;
      name_hi_in     = name_hi_ff;
      lock_in        = lock_ff;
      name_write     = '0;
      job_push       = 1'b0;
      job_data       = '0;
      frame_ok       = 1'b0;

      if (media_done) begin
         lock_in = 1'b0;
      end

      if (accept) begin
         if (off != BYTE_COUNT_MAX) begin
            if (off < OFF_MAGIC_LAST) begin
               if (req_data_byte != expect_byte) begin
                  magic_match_in = 1'b0;
               end
            end else if (off == OFF_TYPE) begin
               type_code_in = req_data_byte;
            end
            if (off == OFF_SENDER) begin
               sender_in = req_data_byte;
            end
            if (off == OFF_MASTER) begin
               claimed_in = (req_data_byte != 8'd0);
            end
            if (off >= OFF_DEVICE && off < OFF_DEVICE + 16'd4) begin
               device_in = {device_ff[23:0], req_data_byte};
            end
            if (off == OFF_SLOT_LOW) begin
               slot_in = req_data_byte;
            end
            if (off >= OFF_NAME && off < OFF_NAME + NAME_BYTES) begin
               if (!rel[0]) begin
                  name_hi_in = req_data_byte;
               end else if (32'(rel[5:1]) < NAME_UNITS) begin
                  name_write.en   = 1'b1;
                  name_write.addr = rel[5:1];
                  name_write.data = {name_hi_ff, req_data_byte};
               end
            end
            if (off >= OFF_TRACKS && off < OFF_TRACKS + 16'd4) begin
               tracks_in = {tracks_ff[23:0], req_data_byte};
            end
            if (off >= OFF_PLAYLISTS && off < OFF_PLAYLISTS + 16'd4) begin
               playlists_in = {playlists_ff[23:0], req_data_byte};
            end
            byte_count_in = byte_count_ff + 16'd1;
         end

         if (req_last_byte) begin
            frame_ok = magic_match_in && (byte_count_in > OFF_MAGIC_LAST);
            if (frame_ok && type_code_in == TYPE_STATUS
                  && byte_count_in >= STATUS_MIN_LEN) begin
               if (claimed_in && sender_in != master_ff) begin
                  master_in       = sender_in;
                  job_push        = 1'b1;
                  job_data.kind   = JOB_MASTER;
                  job_data.master = sender_in;
               end else if (!claimed_in && sender_in == master_ff) begin
                  master_in       = 8'd0;
                  job_push        = 1'b1;
                  job_data.kind   = JOB_MASTER;
               end
            end else if (frame_ok && type_code_in == TYPE_RESPONSE
                  && byte_count_in >= RESP_MIN_LEN) begin
               job_push           = 1'b1;
               job_data.kind      = JOB_MEDIA;
               job_data.device    = device_in;
               job_data.slot      = slot_in;
               job_data.tracks    = tracks_in;
               job_data.playlists = playlists_in;
               lock_in            = 1'b1;
            end
            byte_count_in  = 16'd0;
            magic_match_in = 1'b1;
            type_code_in   = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff <= '0;
         magic_last_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_MAGIC_FIRST_EIGHT) begin
            magic_first_ff <= csr_data;
         end else if (csr_index == CSR_MAGIC_LAST_TWO) begin
            magic_last_ff <= csr_data[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         magic_match_ff <= 1'b1;
         type_code_ff   <= '0;
         sender_ff      <= '0;
         claimed_ff     <= 1'b0;
         device_ff      <= '0;
         slot_ff        <= '0;
         tracks_ff      <= '0;
         playlists_ff   <= '0;
         master_ff      <= '0;
         lock_ff        <= 1'b0;
      end else begin
         byte_count_ff  <= byte_count_in;
         magic_match_ff <= magic_match_in;
         type_code_ff   <= type_code_in;
         sender_ff      <= sender_in;
         claimed_ff     <= claimed_in;
         device_ff      <= device_in;
         slot_ff        <= slot_in;
         tracks_ff      <= tracks_in;
         playlists_ff   <= playlists_in;
         master_ff      <= master_in;
         lock_ff        <= lock_in;
      end
   end

   always_ff @(posedge clock) begin
      name_hi_ff <= name_hi_in;
   end

endmodule

// ===== rtl/msdp_back.sv =====
// ----------------------------------------------------------------------------
// msdp_back
// Job execution: name store, name unit readout, summary and master results.
// ----------------------------------------------------------------------------
module msdp_back
   import msdp_pkg::*;
#(
   parameter int NAME_UNITS = NAME_UNITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  name_write_type name_write,
   input  logic           job_empty,
   input  job_type        job_head,
   output logic           job_pop,
   output logic           res_push,
   output result_type     res_data,
   input  logic           res_full,
   output logic           media_done
);

   localparam int AW = (NAME_UNITS > 1) ? $clog2(NAME_UNITS) : 1;

   logic [15:0]    name_mem [NAME_UNITS];
   logic [15:0]    rd_data_ff;
   back_state_type state_ff, state_in;
   logic [AW-1:0]  idx_ff, idx_in;
   job_type        job_ff, job_in;
   logic           idx_end;

   assign idx_end = (idx_ff == AW'(NAME_UNITS - 1));

   always_ff @(posedge clock) begin
      if (name_write.en) begin
         name_mem[name_write.addr[AW-1:0]] <= name_write.data;
      end
      rd_data_ff <= name_mem[idx_ff];
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      job_in   = job_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!job_empty) begin
               job_in   = job_head;
               idx_in   = '0;
               state_in = (job_head.kind == JOB_MASTER) ? BK_MASTER : BK_READ;
            end
         end
         BK_MASTER: begin
            if (!res_full) begin
               state_in = BK_IDLE;
            end
         end
         BK_READ: begin
            state_in = BK_UNIT;
         end
         BK_UNIT: begin
            if (rd_data_ff == 16'd0) begin
               state_in = BK_SUMMARY;
            end else if (!res_full) begin
               if (idx_end) begin
                  state_in = BK_SUMMARY;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = BK_READ;
               end
            end
         end
         BK_SUMMARY: begin
            if (!res_full) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      job_pop    = 1'b0;
      res_push   = 1'b0;
      res_data   = '0;
      media_done = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            job_pop = !job_empty;
         end
         BK_MASTER: begin
            res_push        = !res_full;
            res_data.kind   = REC_MASTER;
            res_data.master = job_ff.master;
            res_data.last   = 1'b1;
         end
         BK_UNIT: begin
            res_push           = !res_full && (rd_data_ff != 16'd0);
            res_data.kind      = REC_NAME;
            res_data.name_unit = rd_data_ff;
         end
         BK_SUMMARY: begin
            res_push           = !res_full;
            media_done         = !res_full;
            res_data.kind      = REC_SUMMARY;
            res_data.device    = job_ff.device;
            res_data.slot      = job_ff.slot;
            res_data.tracks    = job_ff.tracks;
            res_data.playlists = job_ff.playlists;
            res_data.last      = 1'b1;
         end
         default: begin
            res_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

// ===== rtl/media_status_datagram_parser_top.sv =====
// ----------------------------------------------------------------------------
// media_status_datagram_parser_top
// Sorts datagram payload bytes into tempo master changes and media results.
// ----------------------------------------------------------------------------
//  channel   handshake            beat contents
//  req       req_push / req_full  req_data_byte, req_last_byte
//  rsp       rsp_empty / rsp_pop  record kind, name unit, summary, master
//  csr       csr_valid/csr_ready  csr_index, csr_data (64 bit)
//
//  One byte per cycle is taken while req_full is low. A media response
//  drains each name unit through a read state and a unit state, using the
//  single read port of the name store, and req_full stays high until its
//  summary is queued. Synchronous reset clears all control state; the name
//  store holds no reset. rsp_pop stalls back up through a two-entry result
//  queue, then a two-entry job queue, then the intake.
// ----------------------------------------------------------------------------
module media_status_datagram_parser_top
   import msdp_pkg::*;
#(
   parameter int NAME_UNITS = NAME_UNITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_record_kind,
   output logic [15:0] rsp_name_unit,
   output logic [31:0] rsp_device_number,
   output logic [7:0]  rsp_media_slot,
   output logic [31:0] rsp_track_count,
   output logic [31:0] rsp_playlist_count,
   output logic [7:0]  rsp_master_device,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic           job_push, job_full, job_empty, job_pop;
   job_type        job_data, job_head;
   name_write_type name_write;
   logic           media_done, locked;
   logic           res_push, res_full;
   result_type     res_data, res_head;

   msdp_front #(.NAME_UNITS(NAME_UNITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .job_push      (job_push),
      .job_data      (job_data),
      .job_full      (job_full),
      .media_done    (media_done),
      .name_write    (name_write),
      .locked        (locked)
   );

   msdp_queue #(.ITEM_TYPE(job_type), .DEPTH(JOB_DEPTH)) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .full      (job_full),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (job_empty)
   );

   msdp_back #(.NAME_UNITS(NAME_UNITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .name_write (name_write),
      .job_empty  (job_empty),
      .job_head   (job_head),
      .job_pop    (job_pop),
      .res_push   (res_push),
      .res_data   (res_data),
      .res_full   (res_full),
      .media_done (media_done)
   );

   msdp_queue #(.ITEM_TYPE(result_type), .DEPTH(RES_DEPTH)) u_res_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .head      (res_head),
      .empty     (rsp_empty)
   );

   assign rsp_record_kind    = res_head.kind;
   assign rsp_name_unit      = res_head.name_unit;
   assign rsp_device_number  = res_head.device;
   assign rsp_media_slot     = res_head.slot;
   assign rsp_track_count    = res_head.tracks;
   assign rsp_playlist_count = res_head.playlists;
   assign rsp_master_device  = res_head.master;
   assign rsp_last_result    = res_head.last;

   a_done_while_locked : assert property (@(posedge clock) disable iff (reset)
      media_done |-> locked)
      else $error("summary issued with no media response in flight");

   a_no_name_write_locked : assert property (@(posedge clock) disable iff (reset)
      locked |-> !name_write.en)
      else $error("name store written during readout");

   a_name_not_last : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_record_kind == REC_NAME) |-> (!rsp_last_result
         && rsp_name_unit != 16'd0))
      else $error("bad name unit result");

   a_locked_full : assert property (@(posedge clock) disable iff (reset)
      locked |-> req_full)
      else $error("intake open during media readout");

endmodule

// ===== test/media_status_datagram_parser_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// media_status_datagram_parser_top_tb
// Self-checking bench for the media status datagram parser. Datagrams are
// built byte by byte: status and media response frames with random content,
// plus short, bad-magic, wrong-type and oversized ones. Each accepted byte
// feeds a local parser model, and every popped record is compared in order
// with the model's output. Both sides idle at random, and the header magic
// is rewritten between phases and twice in the middle of a datagram.
// ----------------------------------------------------------------------------
module media_status_datagram_parser_top_tb
   import msdp_pkg::*;
;

   localparam int NAME_UNITS   = NAME_UNITS_DEFAULT;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_FRAMES = 160;

   class parser_model;
      logic [63:0] magic_first_eight;
      logic [15:0] magic_last_two;
      logic [15:0] byte_count;
      bit          magic_ok;
      logic [7:0]  type_code;
      logic [7:0]  sender;
      bit          claimed;
      logic [31:0] device;
      logic [7:0]  slot;
      logic [15:0] names [32];
      logic [31:0] tracks;
      logic [31:0] playlists;
      logic [7:0]  master;
      result_type  expected_records[$];
      int          errors;
      int          datagrams;
      int          bytes_seen;
      int          units_seen;
      int          summaries_seen;
      int          changes_seen;

      function new();
         magic_first_eight = '0;
         magic_last_two    = '0;
         byte_count        = '0;
         magic_ok          = 1'b1;
         type_code         = '0;
         sender            = '0;
         claimed           = 1'b0;
         device            = '0;
         slot              = '0;
         tracks            = '0;
         playlists         = '0;
         master            = '0;
         foreach (names[i]) names[i] = '0;
      endfunction

      function void set_register(logic [7:0] idx, logic [63:0] d);
         case (idx)
            CSR_MAGIC_FIRST_EIGHT: magic_first_eight = d;
            CSR_MAGIC_LAST_TWO:    magic_last_two = d[15:0];
            default: ;
         endcase
      endfunction

      // one accepted input beat; queues the records a final byte produces
      function void accept_byte(logic [7:0] b, bit last);
         int         o;
         int         i;
         int         rel;
         result_type r;
         o = int'(byte_count);
         bytes_seen++;
         if (byte_count != BYTE_COUNT_MAX) begin
            if (o < 8) begin
               if (b != magic_first_eight[(7 - o) * 8 +: 8]) magic_ok = 1'b0;
            end else if (o < 10) begin
               if (b != magic_last_two[(9 - o) * 8 +: 8]) magic_ok = 1'b0;
            end else if (o == OFF_TYPE) begin
               type_code = b;
            end
            if (o == OFF_SENDER) sender = b;
            if (o == OFF_MASTER) claimed = (b != 0);
            if (o >= OFF_DEVICE && o < OFF_DEVICE + 4) device = {device[23:0], b};
            if (o == OFF_SLOT_LOW) slot = b;
            if (o >= OFF_NAME && o < OFF_NAME + NAME_BYTES) begin
               rel = o - OFF_NAME;
               if (rel % 2 == 0) names[rel / 2] = {b, 8'h00};
               else names[rel / 2][7:0] = b;
            end
            if (o >= OFF_TRACKS && o < OFF_TRACKS + 4) tracks = {tracks[23:0], b};
            if (o >= OFF_PLAYLISTS && o < OFF_PLAYLISTS + 4) begin
               playlists = {playlists[23:0], b};
            end
            byte_count++;
         end
         if (!last) return;
         datagrams++;
         if (magic_ok && byte_count > 10) begin
            r = '0;
            r.last = 1'b1;
            r.kind = REC_MASTER;
            if (type_code == TYPE_STATUS && byte_count >= STATUS_MIN_LEN) begin
               if (claimed && sender != master) begin
                  master = sender;
                  r.master = sender;
                  expected_records.push_back(r);
               end else if (!claimed && sender == master) begin
                  master = '0;
                  expected_records.push_back(r);
               end
            end else if (type_code == TYPE_RESPONSE && byte_count >= RESP_MIN_LEN) begin
               i = 0;
               while (i < NAME_UNITS && names[i] != 0) begin
                  r = '0;
                  r.kind = REC_NAME;
                  r.name_unit = names[i];
                  expected_records.push_back(r);
                  i++;
               end
               r = '0;
               r.kind      = REC_SUMMARY;
               r.device    = device;
               r.slot      = slot;
               r.tracks    = tracks;
               r.playlists = playlists;
               r.last      = 1'b1;
               expected_records.push_back(r);
            end
         end
         byte_count = '0;
         magic_ok   = 1'b1;
         type_code  = '0;
      endfunction

      function string describe(result_type r);
         return $sformatf("kind=%0d unit=%h dev=%h slot=%h trk=%h pl=%h mst=%h last=%b",
                          r.kind, r.name_unit, r.device, r.slot, r.tracks,
                          r.playlists, r.master, r.last);
      endfunction

      function void check_record(result_type got);
         result_type want;
         if (expected_records.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected beat %s", describe(got));
            return;
         end
         want = expected_records.pop_front();
         if (got.kind !== want.kind || got.name_unit !== want.name_unit ||
             got.device !== want.device || got.slot !== want.slot ||
             got.tracks !== want.tracks || got.playlists !== want.playlists ||
             got.master !== want.master || got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR: expected %s", describe(want));
               $display("       actual   %s", describe(got));
            end
         end else begin
            case (want.kind)
               REC_NAME:    units_seen++;
               REC_SUMMARY: summaries_seen++;
               default:     changes_seen++;
            endcase
         end
      endfunction

      function void count_leftover();
         if (expected_records.size() != 0) begin
            errors += expected_records.size();
            $display("ERROR: %0d records never arrived", expected_records.size());
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [1:0]  rsp_record_kind;
   logic [15:0] rsp_name_unit;
   logic [31:0] rsp_device_number;
   logic [7:0]  rsp_media_slot;
   logic [31:0] rsp_track_count;
   logic [31:0] rsp_playlist_count;
   logic [7:0]  rsp_master_device;
   logic        rsp_last_result;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [63:0] csr_data;

   parser_model pm = new();
   logic [7:0]  frame[$];
   bit          idle_en = 1'b1;
   int          reg_writes;

   media_status_datagram_parser_top #(
      .NAME_UNITS(NAME_UNITS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_record_kind    (rsp_record_kind),
      .rsp_name_unit      (rsp_name_unit),
      .rsp_device_number  (rsp_device_number),
      .rsp_media_slot     (rsp_media_slot),
      .rsp_track_count    (rsp_track_count),
      .rsp_playlist_count (rsp_playlist_count),
      .rsp_master_device  (rsp_master_device),
      .rsp_last_result    (rsp_last_result),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // random fill, header from the current magic, type byte at offset 10
   function automatic void new_frame(int len, logic [7:0] kind_byte);
      int k;
      frame.delete();
      for (k = 0; k < len; k++) frame.push_back(8'($urandom_range(0, 255)));
      for (k = 0; k < 8 && k < len; k++) frame[k] = pm.magic_first_eight[(7 - k) * 8 +: 8];
      for (k = 8; k < 10 && k < len; k++) frame[k] = pm.magic_last_two[(9 - k) * 8 +: 8];
      if (len > OFF_TYPE) frame[OFF_TYPE] = kind_byte;
   endfunction

   function automatic void put_word(int off, logic [31:0] w);
      int k;
      for (k = 0; k < 4; k++) frame[off + k] = w[(3 - k) * 8 +: 8];
   endfunction

   function automatic void put_unit(int idx, logic [15:0] u);
      frame[OFF_NAME + 2 * idx]     = u[15:8];
      frame[OFF_NAME + 2 * idx + 1] = u[7:0];
   endfunction

   function automatic void make_response(int len, int units, logic [31:0] dev,
                                         logic [7:0] slot, logic [31:0] trk,
                                         logic [31:0] pl);
      int k;
      new_frame(len, TYPE_RESPONSE);
      put_word(int'(OFF_DEVICE), dev);
      frame[OFF_SLOT_LOW] = slot;
      for (k = 0; k < 32; k++) begin
         if (k < units) put_unit(k, 16'($urandom_range(1, 65535)));
         else if (k == units) put_unit(k, 16'h0000);
      end
      put_word(int'(OFF_TRACKS), trk);
      put_word(int'(OFF_PLAYLISTS), pl);
   endfunction

   function automatic void make_status(int len, logic [7:0] sender, logic [7:0] mbyte);
      new_frame(len, TYPE_STATUS);
      if (len > OFF_SENDER) frame[OFF_SENDER] = sender;
      if (len > OFF_MASTER) frame[OFF_MASTER] = mbyte;
   endfunction

   // sends frame[first .. stop-1]; the final byte of the frame carries last
   task automatic send_frame(int first, int stop);
      int  long_at;
      int  i;
      bit  last;
      long_at = ($urandom_range(0, 3) == 0) ? $urandom_range(first, stop - 1) : -1;
      for (i = first; i < stop; i++) begin
         last = (i == frame.size() - 1);
         if (idle_en && (i == long_at || (i == 0 && $urandom_range(0, 9) == 0))) begin
            req_push <= 1'b0;
            repeat ($urandom_range(8, 40)) @(posedge clock);
         end else if (idle_en && $urandom_range(0, 99) < 15) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         req_push      <= 1'b1;
         req_data_byte <= frame[i];
         req_last_byte <= last;
         @(posedge clock);
         while (req_full) @(posedge clock);
         pm.accept_byte(frame[i], last);
      end
   endtask

   task automatic send_all();
      send_frame(0, frame.size());
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (pm.expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [7:0] idx, logic [63:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      pm.set_register(idx, d);
      reg_writes++;
      @(posedge clock);
   endtask

   // result side: check the beat taken at this edge, then pick the next pop
   initial begin
      int         stall;
      int         r;
      result_type got;
      stall = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.kind      = record_kind_type'(rsp_record_kind);
            got.name_unit = rsp_name_unit;
            got.device    = rsp_device_number;
            got.slot      = rsp_media_slot;
            got.tracks    = rsp_track_count;
            got.playlists = rsp_playlist_count;
            got.master    = rsp_master_device;
            got.last      = rsp_last_result;
            pm.check_record(got);
         end
         if (stall == 0 && idle_en) begin
            r = $urandom_range(0, 99);
            if (r < 2) stall = $urandom_range(8, 40);
            else if (r < 12) stall = $urandom_range(1, 3);
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      int          n;
      int          k;
      int          pick;
      int          wait_count;
      logic [7:0]  sender;
      logic [63:0] new_magic;

      reset         <= 1'b1;
      req_push      <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_data      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: all-zero magic first
      write_register(CSR_MAGIC_FIRST_EIGHT, '0);
      write_register(CSR_MAGIC_LAST_TWO, '0);
      make_response(int'(RESP_MIN_LEN), 32, '1, 8'hFF, '1, '0);
      send_all();
      make_response(RESP_MIN_LEN + 5, 0, '0, '0, '0, '1);
      send_all();
      make_response(int'(RESP_MIN_LEN), 3, $urandom, 8'h01, $urandom, $urandom);
      put_unit(0, 16'hFFFF);
      put_unit(1, 16'h00FF);
      put_unit(2, 16'hFF00);
      send_all();
      make_response(RESP_MIN_LEN - 1, 5, $urandom, 8'h03, $urandom, $urandom);
      send_all();
      make_status(int'(STATUS_MIN_LEN), 8'd5, 8'h01);
      send_all();
      make_status(STATUS_MIN_LEN - 1, 8'd9, 8'h01);
      send_all();
      make_status(STATUS_MIN_LEN + 3, 8'd5, 8'hFF);
      send_all();
      make_status(int'(STATUS_MIN_LEN), 8'd7, 8'h80);
      send_all();
      make_status(int'(STATUS_MIN_LEN), 8'd5, 8'h00);
      send_all();
      make_status(int'(STATUS_MIN_LEN), 8'd7, 8'h00);
      send_all();
      make_status(int'(STATUS_MIN_LEN), 8'd0, 8'h00);
      send_all();
      make_status(int'(STATUS_MIN_LEN), 8'd0, 8'h01);
      send_all();
      make_response(200, 4, $urandom, 8'h02, $urandom, $urandom);
      frame[OFF_TYPE] = 8'h0B;
      send_all();
      new_frame(1, 8'h00);
      send_all();
      new_frame(11, TYPE_RESPONSE);
      send_all();
      make_response(int'(RESP_MIN_LEN), 4, $urandom, 8'h02, $urandom, $urandom);
      frame[9] ^= 8'h01;
      send_all();
      make_response(int'(RESP_MIN_LEN), 4, $urandom, 8'h02, $urandom, $urandom);
      frame[0] ^= 8'h80;
      send_all();

      // all-ones magic
      wait_idle();
      write_register(CSR_MAGIC_FIRST_EIGHT, '1);
      write_register(CSR_MAGIC_LAST_TWO, 64'hFFFF);
      make_response(RESP_MIN_LEN + 1, 31, $urandom, 8'($urandom), $urandom, $urandom);
      send_all();
      make_status(int'(STATUS_MIN_LEN), 8'hFF, 8'h01);
      send_all();

      // magic rewritten mid-datagram: early bytes keep the old value
      wait_idle();
      new_magic = {$urandom, $urandom};
      new_magic[23:0] = ~pm.magic_first_eight[23:0];
      make_response(int'(RESP_MIN_LEN), 6, $urandom, 8'($urandom), $urandom, $urandom);
      for (k = 5; k < 8; k++) frame[k] = new_magic[(7 - k) * 8 +: 8];
      send_frame(0, 5);
      wait_idle();
      write_register(CSR_MAGIC_FIRST_EIGHT, new_magic);
      send_frame(5, frame.size());
      wait_idle();
      make_response(int'(RESP_MIN_LEN), 6, $urandom, 8'($urandom), $urandom, $urandom);
      frame[0] ^= 8'h80;
      send_frame(0, 5);
      wait_idle();
      write_register(CSR_MAGIC_FIRST_EIGHT, new_magic ^ 64'h8000_0000_0000_0000);
      send_frame(5, frame.size());

      // oversized datagram: byte counter saturates
      idle_en = 1'b0;
      make_response(65541, 32, $urandom, 8'($urandom), $urandom, $urandom);
      send_all();
      idle_en = 1'b1;

      for (n = 0; n < RANDOM_FRAMES; n++) begin
         if (n % 40 == 0) begin
            wait_idle();
            write_register(CSR_MAGIC_FIRST_EIGHT, {$urandom, $urandom});
            write_register(CSR_MAGIC_LAST_TWO, 64'($urandom_range(0, 65535)));
         end else if (n % 10 == 0) begin
            wait_idle();
         end
         idle_en = !(n >= 60 && n < 80);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            make_response(RESP_MIN_LEN + $urandom_range(0, 24),
                          ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(0, 31),
                          $urandom, 8'($urandom), $urandom, $urandom);
         end else if (pick < 80) begin
            case ($urandom_range(0, 3))
               0:       sender = pm.master;
               1:       sender = 8'd0;
               2:       sender = 8'($urandom_range(1, 4));
               default: sender = 8'($urandom_range(1, 255));
            endcase
            make_status(STATUS_MIN_LEN + $urandom_range(0, 16), sender,
                        $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255)));
         end else begin
            case ($urandom_range(0, 4))
               0: begin
                  new_frame($urandom_range(1, 60), 8'($urandom_range(0, 255)));
                  if ($urandom_range(0, 1)) begin
                     for (k = 0; k < 10 && k < frame.size(); k++) begin
                        frame[k] = 8'($urandom_range(0, 255));
                     end
                  end
               end
               1: make_response($urandom_range(11, RESP_MIN_LEN - 1), 8,
                                $urandom, 8'($urandom), $urandom, $urandom);
               2: make_status($urandom_range(11, STATUS_MIN_LEN - 1), pm.master ^ 8'h01,
                              8'h01);
               3: begin
                  make_response(int'(RESP_MIN_LEN), 5, $urandom, 8'($urandom),
                                $urandom, $urandom);
                  k = $urandom_range(0, 9);
                  frame[k] ^= 8'(1 << $urandom_range(0, 7));
               end
               default: begin
                  make_response(180, 5, $urandom, 8'($urandom), $urandom, $urandom);
                  frame[OFF_TYPE] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
               end
            endcase
         end
         send_all();
      end

      req_push <= 1'b0;
      wait_count = 0;
      while (pm.expected_records.size() != 0 && wait_count < 100000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      pm.count_leftover();
      $display("covered %0d datagrams, %0d bytes, %0d register writes",
               pm.datagrams, pm.bytes_seen, reg_writes);
      $display("matched %0d name units, %0d summaries, %0d master changes, %0d errors",
               pm.units_seen, pm.summaries_seen, pm.changes_seen, pm.errors);
      if (pm.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/msdp_pkg.sv
rtl/msdp_queue.sv
rtl/msdp_front.sv
rtl/msdp_back.sv
rtl/media_status_datagram_parser_top.sv
test/media_status_datagram_parser_top_tb.sv
